// ===== hw/rtl/sha_pkg.sv =====
package sha_pkg;

	localparam int BlockBytes = 64;
	localparam int BlockWords = 16;
	localparam int HashWords = 8;
	localparam int Rounds = 64;
	localparam int LenOffset = 56;

	typedef enum logic [1:0] {
		CMD_START    = 2'd0,
		CMD_DATA     = 2'd1,
		CMD_COMPLETE = 2'd2,
		CMD_UNUSED   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} rsp_t;

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] r;
		unique case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};
		return k[i];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== hw/rtl/sha_stream_if.sv =====
interface sha_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/sha_ram.sv =====
module sha_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/sha_core.sv =====
module sha_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        from_init,
	input  logic        w_load,
	input  logic [31:0] w_in,
	output logic        done,
	output logic        busy,
	input  logic        hash_clear,
	input  logic [2:0]  hash_sel,
	output logic [31:0] hash_word
);
	logic [31:0] h_q [sha_pkg::HashWords];
	logic [31:0] v_q [sha_pkg::HashWords];
	logic [31:0] w_q [sha_pkg::BlockWords];
	logic [5:0]  round_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] w_cur;
	logic [31:0] w_next;
	logic [31:0] s0;
	logic [31:0] s1;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] e;
	logic [31:0] a;

	assign done = done_q;
	assign busy = busy_q;
	assign hash_word = h_q[hash_sel];

	always_comb begin
		s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_cur = w_q[0];
		w_next = s1 + w_q[9] + s0 + w_q[0];
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::round_k(round_q) + w_cur;
		t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			round_q <= '0;
			for (int i = 0; i < sha_pkg::HashWords; i++) begin
				h_q[i] <= sha_pkg::init_h(3'(i));
				v_q[i] <= '0;
			end
			for (int i = 0; i < sha_pkg::BlockWords; i++) begin
				w_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (hash_clear) begin
				for (int i = 0; i < sha_pkg::HashWords; i++) begin
					h_q[i] <= '0;
				end
			end
			if (start && from_init) begin
				for (int i = 0; i < sha_pkg::HashWords; i++) begin
					h_q[i] <= sha_pkg::init_h(3'(i));
				end
			end else if (start) begin
				busy_q <= 1'b1;
				round_q <= '0;
				for (int i = 0; i < sha_pkg::HashWords; i++) begin
					v_q[i] <= h_q[i];
				end
			end else if (busy_q) begin
				for (int i = 0; i < sha_pkg::BlockWords - 1; i++) begin
					w_q[i] <= w_q[i + 1];
				end
				w_q[sha_pkg::BlockWords - 1] <= w_next;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= e;
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= a;
				v_q[0] <= t1 + t2;
				round_q <= round_q + 6'd1;
				if (round_q == 6'(sha_pkg::Rounds - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q) begin
				for (int i = 0; i < sha_pkg::HashWords; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end else if (w_load) begin
				for (int i = 0; i < sha_pkg::BlockWords - 1; i++) begin
					w_q[i] <= w_q[i + 1];
				end
				w_q[sha_pkg::BlockWords - 1] <= w_in;
			end
		end
	end

`ifndef SYNTHESIS
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without round");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("restart while busy");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !w_load) else $error("schedule load while busy");
`endif
endmodule

// ===== hw/rtl/sha256_stream_hasher_unit.sv =====
// SHA-256 hasher, one request per byte. A start or data request leaves the unit idle unless
// the data byte fills the 64-byte block; then the block buffer RAM is read out one byte per
// cycle into the message schedule, the round unit starts, runs 64 rounds, one per cycle, and
// folds into the hash, and the input holds until the fold is done. A complete request writes
// the pad bytes one per cycle to the end of the block and hashes it, with a second block when
// fewer than nine bytes were free; then it sends the eight digest words on the response
// channel, word 0 first, with valid low between words, and clears the hash to zero.
// Requests are accepted only while the unit is idle.
module sha256_stream_hasher_unit (
	input logic clk,
	input logic arst_n,
	sha_stream_if.sink   req,
	sha_stream_if.source rsp
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_RUN,
		ST_ADD,
		ST_EMIT
	} state_t;

	state_t       state_q;
	logic [5:0]   fill_q;
	logic [60:0]  bytes_q;
	logic         final_q;
	logic         second_q;
	logic [2:0]   emit_q;
	logic         rsp_valid_q;
	logic [31:0]  rsp_word_q;
	logic [6:0]   rd_q;
	logic         rd_valid_s1;
	logic [5:0]   rd_pos_s1;
	logic         go_q;
	logic [23:0]  wacc_q;

	logic         we;
	logic [5:0]   waddr;
	logic [7:0]   wdata;
	logic [5:0]   raddr;
	logic [7:0]   rdata;

	logic         core_start;
	logic         core_init;
	logic         w_load;
	logic [31:0]  w_in;
	logic         done;
	logic         busy;
	logic         hash_clear;
	logic [31:0]  hash_word;
	logic [63:0]  bits;
	logic         accept;
	sha_pkg::req_t r;

	assign r = req.payload;
	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign bits = {bytes_q, 3'b000};
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = '{digest_word: rsp_word_q, word_index: emit_q,
		last_word: (emit_q == 3'd7)};
	assign hash_clear = rsp.valid && rsp.ready && (emit_q == 3'd7);

	assign raddr = rd_q[5:0];
	assign w_in = {wacc_q, rdata};
	assign w_load = rd_valid_s1 && (rd_pos_s1[1:0] == 2'd3);

	always_comb begin
		we = 1'b0;
		waddr = fill_q;
		wdata = r.data_byte;
		core_start = 1'b0;
		core_init = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && r.cmd == sha_pkg::CMD_DATA) begin
					we = 1'b1;
				end else if (accept && r.cmd == sha_pkg::CMD_START) begin
					core_init = 1'b1;
					core_start = 1'b1;
				end else if (accept && r.cmd == sha_pkg::CMD_COMPLETE) begin
					we = 1'b1;
					wdata = 8'h80;
				end
			end
			ST_PAD: begin
				we = 1'b1;
				wdata = 8'h00;
			end
			ST_LEN: begin
				we = 1'b1;
				wdata = bits[8'(7 - fill_q[2:0]) * 8 +: 8];
			end
			default: ;
		endcase
	end

	sha_ram #(.Width(8), .Depth(sha_pkg::BlockBytes)) u_buf (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n),
		.start(core_start || go_q), .from_init(core_init),
		.w_load(w_load), .w_in(w_in), .done(done), .busy(busy),
		.hash_clear(hash_clear), .hash_sel(emit_q), .hash_word(hash_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			bytes_q <= '0;
			final_q <= 1'b0;
			second_q <= 1'b0;
			emit_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_word_q <= '0;
			rd_q <= '0;
			rd_valid_s1 <= 1'b0;
			rd_pos_s1 <= '0;
			go_q <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_RUN) && !rd_q[6];
			rd_pos_s1 <= rd_q[5:0];
			go_q <= rd_valid_s1 && (rd_pos_s1 == 6'(sha_pkg::BlockBytes - 1));
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (sha_pkg::cmd_t'(r.cmd))
							sha_pkg::CMD_START: begin
								fill_q <= '0;
								bytes_q <= '0;
							end
							sha_pkg::CMD_DATA: begin
								bytes_q <= bytes_q + 61'd1;
								fill_q <= fill_q + 6'd1;
								final_q <= 1'b0;
								if (fill_q == 6'(sha_pkg::BlockBytes - 1)) begin
									state_q <= ST_RUN;
									rd_q <= '0;
								end
							end
							sha_pkg::CMD_COMPLETE: begin
								final_q <= 1'b1;
								second_q <= (fill_q >= 6'(sha_pkg::LenOffset));
								fill_q <= fill_q + 6'd1;
								if (fill_q == 6'(sha_pkg::BlockBytes - 1)) begin
									state_q <= ST_RUN;
									rd_q <= '0;
								end else if (fill_q == 6'(sha_pkg::LenOffset - 1)) begin
									state_q <= ST_LEN;
								end else begin
									state_q <= ST_PAD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'(sha_pkg::BlockBytes - 1)) begin
						state_q <= ST_RUN;
						rd_q <= '0;
					end else if (fill_q == 6'(sha_pkg::LenOffset - 1) && !second_q) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'(sha_pkg::BlockBytes - 1)) begin
						state_q <= ST_RUN;
						rd_q <= '0;
					end
				end
				ST_RUN: begin
					if (!rd_q[6]) begin
						rd_q <= rd_q + 7'd1;
					end
					if (done) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (!final_q) begin
						state_q <= ST_IDLE;
					end else if (second_q) begin
						second_q <= 1'b0;
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_EMIT;
						emit_q <= '0;
						rsp_valid_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (!rsp_valid_q) begin
						rsp_valid_q <= 1'b1;
						rsp_word_q <= hash_word;
					end else if (rsp.ready) begin
						rsp_valid_q <= 1'b0;
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							final_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			wacc_q <= {wacc_q[15:0], rdata};
		end
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !req.ready) else $error("request taken during rounds");
	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> state_q == ST_EMIT) else $error("response outside emit");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		hash_clear |=> state_q == ST_IDLE) else $error("no return to idle");
`endif
endmodule
